[hw/rtl/spk_pkg.sv]
// Shared types, constants and status codes for the shelf rectangle packer.
// Used by spk_cell, shelf_rect_packer and the testbench; depends on nothing else.
package spk_pkg;

  localparam int MAX_ROWS = 64;
  localparam int IDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W    = $clog2(MAX_ROWS + 1);
  localparam int COORD_W  = 13;
  localparam int STAT_W   = 3;

  localparam logic [COORD_W-1:0] ATLAS_RESET = 13'd1024;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  localparam logic [STAT_W-1:0] ST_EXISTING = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEWROW   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOSPACE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } result_t;

  // Search token travelling down the cell chain
  typedef struct packed {
    logic               active;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic               found;
    logic [IDX_W-1:0]   best_idx;
    logic [COORD_W-1:0] best_h;
    logic [COORD_W-1:0] best_x;
    logic [COORD_W-1:0] best_y;
  } tok_t;

  // Broadcast write into one cell of the chain
  typedef struct packed {
    logic               en;
    logic               new_row;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] fill;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] height;
  } row_wr_t;

endpackage

[hw/rtl/spk_cell.sv]
// One shelf row of the packer: holds fill position, top and height and
// folds its fit test into the passing search token. Depends on spk_pkg.
module spk_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [spk_pkg::IDX_W-1:0]   idx,
  input  logic [spk_pkg::CNT_W-1:0]   row_count,
  input  logic [spk_pkg::COORD_W-1:0] atlas_size,
  input  spk_pkg::row_wr_t            row_wr,
  input  spk_pkg::tok_t               tok_in,
  output spk_pkg::tok_t               tok_out
);
  import spk_pkg::*;

  logic [COORD_W-1:0] fill_x;
  logic [COORD_W-1:0] top_y;
  logic [COORD_W-1:0] height;
  tok_t               tok;
  tok_t               tok_next;

  logic               in_use;
  logic               fits;
  logic [COORD_W:0]   right_edge;
  logic [COORD_W:0]   bottom_edge;

  always_comb begin
    in_use      = {{(CNT_W-IDX_W){1'b0}}, idx} < row_count;
    right_edge  = {1'b0, fill_x} + {1'b0, tok_in.w};
    bottom_edge = {1'b0, top_y} + {1'b0, tok_in.h};
    fits = in_use && (right_edge <= {1'b0, atlas_size})
        && (bottom_edge <= {1'b0, atlas_size}) && (height >= tok_in.h)
        && (!tok_in.found || (height < tok_in.best_h));
    tok_next = tok_in;
    if (fits) begin
      tok_next.found    = 1'b1;
      tok_next.best_idx = idx;
      tok_next.best_h   = height;
      tok_next.best_x   = fill_x;
      tok_next.best_y   = top_y;
    end
  end

  // Row store: written by the controller's broadcast, no reset
  always_ff @(posedge clk) begin
    if (row_wr.en && (row_wr.idx == idx)) begin
      fill_x <= row_wr.fill;
      if (row_wr.new_row) begin
        top_y  <= row_wr.top;
        height <= row_wr.height;
      end
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.active <= 1'b0;
    end else begin
      tok.active <= tok_next.active;
    end
    tok.w        <= tok_next.w;
    tok.h        <= tok_next.h;
    tok.found    <= tok_next.found;
    tok.best_idx <= tok_next.best_idx;
    tok.best_h   <= tok_next.best_h;
    tok.best_x   <= tok_next.best_x;
    tok.best_y   <= tok_next.best_y;
  end

  assign tok_out = tok;

endmodule

[hw/rtl/shelf_rect_packer.sv]
// Top level of the shelf rectangle packer: command port, controller and
// the chain of spk_cell row cells. Depends on spk_pkg and spk_cell.
//
//  channel   ports                       handshake
//  -------   -------------------------   -------------------------------
//  request   start, busy, req            beat taken when start && !busy
//  result    done, result                one-cycle strobe, always taken
//  config    cfg_wr_en, cfg_wr_data      atlas_size written when cfg_wr_en
//
// Timing: a clear, or an insert into an empty page, returns its result in
// the next cycle and leaves busy low. Any other insert sends a search token
// through all MAX_ROWS cells, one cell per cycle, and returns its result
// once the token leaves the last cell; busy stays high until then.
// The length of the cell chain sets how long a search takes.
// Reset: synchronous, clears the row count, the chain's token flags and the
// result strobe and loads atlas_size with 1024; the row store is not reset.
// Stalls: the receiver cannot stall, so a result is never held back.
module shelf_rect_packer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  spk_pkg::req_t               req,
  output logic                        done,
  output spk_pkg::result_t            result,
  input  logic                        cfg_wr_en,
  input  logic [spk_pkg::COORD_W-1:0] cfg_wr_data
);
  import spk_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic               state;
  logic               state_next;
  logic [COORD_W-1:0] atlas_size;
  logic [CNT_W-1:0]   row_count;
  logic [CNT_W-1:0]   row_count_next;
  logic [COORD_W-1:0] last_bottom;
  logic [COORD_W-1:0] last_bottom_next;
  logic               res_valid_next;
  result_t            res_next;
  result_t            res;
  logic               res_valid;

  logic               accept;
  row_wr_t            row_wr;
  tok_t               tok_head;
  tok_t               chain [0:MAX_ROWS];
  tok_t               tok_end;
  logic [MAX_ROWS-1:0] tok_live;
  logic [COORD_W:0]   new_bottom;
  logic [COORD_W:0]   idle_bottom;

  assign busy    = (state == S_SCAN);
  assign accept  = start && !busy;
  assign tok_end = chain[MAX_ROWS];

  // Inject a fresh token into the first cell on an insert beat that has
  // rows to search; otherwise the chain carries an idle token.
  always_comb begin
    tok_head          = '0;
    tok_head.active   = accept && (req.func == FUNC_INSERT) && (row_count != '0);
    tok_head.w        = req.rect_width;
    tok_head.h        = req.rect_height;
  end

  assign chain[0] = tok_head;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ROWS; gi++) begin : g_row
      spk_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .idx        (IDX_W'(gi)),
        .row_count  (row_count),
        .atlas_size (atlas_size),
        .row_wr     (row_wr),
        .tok_in     (chain[gi]),
        .tok_out    (chain[gi+1])
      );
      assign tok_live[gi] = chain[gi+1].active;
    end
  endgenerate

  // Bottom edge of the page if a new row were opened for this rectangle
  assign new_bottom  = {1'b0, last_bottom} + {1'b0, tok_end.h};
  assign idle_bottom = {1'b0, req.rect_height};

  // Controller: decide the outcome when a beat is simple, or when the
  // search token drops out of the last cell.
  always_comb begin
    state_next       = state;
    row_count_next   = row_count;
    last_bottom_next = last_bottom;
    res_valid_next   = 1'b0;
    res_next         = '0;
    row_wr           = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.func == FUNC_CLEAR) begin
            row_count_next  = '0;
            res_valid_next  = 1'b1;
            res_next.status = ST_CLEARED;
          end else if (row_count == '0) begin
            // First row of an empty page always opens at the origin
            row_wr.en        = 1'b1;
            row_wr.new_row   = 1'b1;
            row_wr.idx       = '0;
            row_wr.fill      = req.rect_width;
            row_wr.top       = '0;
            row_wr.height    = req.rect_height;
            row_count_next   = CNT_W'(1);
            last_bottom_next = idle_bottom[COORD_W-1:0];
            res_valid_next   = 1'b1;
            res_next.status  = ST_NEWROW;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tok_end.active) begin
          state_next     = S_IDLE;
          res_valid_next = 1'b1;
          if (tok_end.found) begin
            // Advance the fill position of the winning row
            row_wr.en       = 1'b1;
            row_wr.idx      = tok_end.best_idx;
            row_wr.fill     = tok_end.best_x + tok_end.w;
            res_next.status = ST_EXISTING;
            res_next.pos_x  = tok_end.best_x;
            res_next.pos_y  = tok_end.best_y;
          end else if (new_bottom > {1'b0, atlas_size}) begin
            res_next.status = ST_NOSPACE;
          end else if (row_count == CNT_W'(MAX_ROWS)) begin
            res_next.status = ST_FULL;
          end else begin
            // Open a new row directly below the last one
            row_wr.en        = 1'b1;
            row_wr.new_row   = 1'b1;
            row_wr.idx       = row_count[IDX_W-1:0];
            row_wr.fill      = tok_end.w;
            row_wr.top       = last_bottom;
            row_wr.height    = tok_end.h;
            row_count_next   = row_count + CNT_W'(1);
            last_bottom_next = new_bottom[COORD_W-1:0];
            res_next.status  = ST_NEWROW;
            res_next.pos_y   = last_bottom;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      row_count  <= '0;
      res_valid  <= 1'b0;
      atlas_size <= ATLAS_RESET;
    end else begin
      state     <= state_next;
      row_count <= row_count_next;
      res_valid <= res_valid_next;
      if (cfg_wr_en) begin
        atlas_size <= cfg_wr_data;
      end
    end
    last_bottom <= last_bottom_next;
    res         <= res_next;
  end

  assign done   = res_valid;
  assign result = res;

  // At most one search token lives in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_live))
    else $error("more than one search token in the cell chain");

  // A token only leaves the chain while a search is running
  a_tok_busy: assert property (@(posedge clk) disable iff (rst)
    tok_end.active |-> busy)
    else $error("search token arrived outside a scan");

  // Row count never passes the store depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    row_count <= CNT_W'(MAX_ROWS))
    else $error("row count beyond row store depth");

  // A clear beat empties the page and reports cleared next cycle
  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && (req.func == FUNC_CLEAR)
    |=> (row_count == '0) && done && (result.status == ST_CLEARED))
    else $error("clear did not empty the page");

  // Failed or clear results carry no position
  a_zero_pos: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ST_NOSPACE || result.status == ST_FULL
             || result.status == ST_CLEARED)
    |-> (result.pos_x == '0) && (result.pos_y == '0))
    else $error("position set on a result with nothing placed");

endmodule

[test/shelf_monitor.sv]
`timescale 1ns / 100ps
// Checker for the shelf rectangle packer: watches the request, result and config channels,
// predicts each placement from its own copy of the shelf store and compares field by field.
// Depends on spk_pkg for the beat types, sizes and status codes.
module shelf_monitor
  import spk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  req_t               req,
  input  logic               done,
  input  result_t            result,
  input  logic               cfg_wr_en,
  input  logic [COORD_W-1:0] cfg_wr_data,
  output int unsigned        mismatches,
  output int unsigned        awaited
);

  logic [COORD_W-1:0] atlas;
  logic [COORD_W-1:0] fill_x  [MAX_ROWS];
  logic [COORD_W-1:0] top_y   [MAX_ROWS];
  logic [COORD_W-1:0] shelf_h [MAX_ROWS];
  int unsigned        shelves;
  result_t            placements_due [$];

  initial begin
    mismatches = 0;
    awaited    = 0;
  end

  function automatic void open_shelf(input int unsigned fill, input int unsigned top,
                                     input int unsigned height);
    fill_x[shelves]  = fill[COORD_W-1:0];
    top_y[shelves]   = top[COORD_W-1:0];
    shelf_h[shelves] = height[COORD_W-1:0];
    shelves++;
  endfunction

  // Best-height fit over the stored shelves; sums are taken at 32 bits, so nothing wraps.
  function automatic result_t place_rect(input req_t r);
    result_t     res;
    int unsigned w, h, best_h, bottom;
    int          best;
    bit          found;
    res    = '0;
    w      = r.rect_width;
    h      = r.rect_height;
    best   = 0;
    best_h = 0;
    found  = 1'b0;
    if (r.func == FUNC_CLEAR) begin
      shelves    = 0;
      res.status = ST_CLEARED;
      return res;
    end
    // An empty page always takes the rectangle at the origin, whatever its size.
    if (shelves == 0) begin
      open_shelf(w, 0, h);
      res.status = ST_NEWROW;
      return res;
    end
    for (int i = 0; i < shelves; i++) begin
      if (int'(fill_x[i]) + w <= int'(atlas) && int'(top_y[i]) + h <= int'(atlas) &&
          int'(shelf_h[i]) >= h && (!found || int'(shelf_h[i]) < best_h)) begin
        found  = 1'b1;
        best   = i;
        best_h = shelf_h[i];
      end
    end
    if (found) begin
      res.status   = ST_EXISTING;
      res.pos_x    = fill_x[best];
      res.pos_y    = top_y[best];
      fill_x[best] = fill_x[best] + w[COORD_W-1:0];
      return res;
    end
    bottom = int'(top_y[shelves-1]) + int'(shelf_h[shelves-1]);
    if (bottom + h > int'(atlas)) begin
      res.status = ST_NOSPACE;
    end else if (shelves >= MAX_ROWS) begin
      res.status = ST_FULL;
    end else begin
      open_shelf(w, bottom, h);
      res.status = ST_NEWROW;
      res.pos_y  = bottom[COORD_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t due;
    if (rst) begin
      atlas   = ATLAS_RESET;
      shelves = 0;
      placements_due.delete();
    end else begin
      if (cfg_wr_en) atlas = cfg_wr_data;
      if (done) begin
        if (placements_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat: status %0d x %0d y %0d",
                     result.status, result.pos_x, result.pos_y);
          mismatches++;
        end else begin
          due = placements_due.pop_front();
          if (result.status !== due.status || result.pos_x !== due.pos_x ||
              result.pos_y !== due.pos_y) begin
            if (mismatches < 10)
              $display("mismatch: expected status %0d x %0d y %0d, got status %0d x %0d y %0d",
                       due.status, due.pos_x, due.pos_y,
                       result.status, result.pos_x, result.pos_y);
            mismatches++;
          end
        end
      end
      if (start && !busy) placements_due.push_back(place_rect(req));
    end
    awaited = placements_due.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// Top of the shelf rectangle packer testbench: clock, reset, request and config stimulus,
// and the verdict. Depends on spk_pkg, shelf_rect_packer and the shelf_monitor checker.
module testbench;
  import spk_pkg::*;

  // Watchdog limit, set well above the slowest run.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned PHASE_ITEMS  = 180;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               busy;
  req_t               req         = '0;
  logic               done;
  result_t            result;
  logic               cfg_wr_en   = 1'b0;
  logic [COORD_W-1:0] cfg_wr_data = '0;

  int unsigned        mismatches;
  int unsigned        awaited;
  int unsigned        cycles      = 0;
  int unsigned        atlas_now   = ATLAS_RESET;
  bit                 burst       = 1'b0;

  always #1 clk = ~clk;

  shelf_rect_packer uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  shelf_monitor monitor (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .awaited     (awaited)
  );

  // Watchdog: give up if the run hangs anywhere.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one request beat from a falling edge and hold it until the block takes it.
  // Return at the falling edge after the beat, with start still high, so that a
  // following beat can go straight out without start dropping in between.
  task automatic issue(input logic f, input int unsigned w, input int unsigned h);
    req_t r;
    r.func        = f;
    r.rect_width  = w[COORD_W-1:0];
    r.rect_height = h[COORD_W-1:0];
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start for a gap of length n; n of zero keeps the request channel back to back.
  task automatic rest(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Mostly short gaps, now and then a long one that can outlast a whole row search.
  function automatic int unsigned pick_gap();
    int unsigned p;
    if (burst) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  task automatic beat(input logic f, input int unsigned w, input int unsigned h);
    issue(f, w, h);
    rest(pick_gap());
  endtask

  // Wait until every predicted result has come back, then let the chain drain.
  task automatic settle();
    start <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (MAX_ROWS + 4) @(negedge clk);
  endtask

  // Write atlas_size only once the block has gone quiet.
  task automatic set_atlas(input int unsigned v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[COORD_W-1:0];
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    atlas_now    = v & 13'h1FFF;
    @(negedge clk);
  endtask

  // One random request. In stacking mode the rectangles are wide and flat, so nearly every
  // insert opens a new row and the row store fills up; otherwise the sizes follow the
  // page so that rows get reused, tie on height and run out of room.
  task automatic random_beat(input bit stacking);
    int unsigned p, w, h, hs;
    p  = $urandom_range(0, 99);
    hs = atlas_now / 12 + 1;
    if (p < (stacking ? 2 : 3)) begin
      beat(FUNC_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 8191));
    end else if (p < 8) begin
      beat(FUNC_INSERT, $urandom() & 13'h1FFF, $urandom() & 13'h1FFF);
    end else if (stacking) begin
      beat(FUNC_INSERT, $urandom_range(1500, 4096), $urandom_range(0, 8));
    end else begin
      w = $urandom_range(0, atlas_now / 3 + 1);
      case ($urandom_range(0, 3))
        0:       h = hs / 4;
        1:       h = hs / 2;
        2:       h = hs;
        default: h = $urandom_range(0, hs);
      endcase
      beat(FUNC_INSERT, w, h);
    end
  endtask

  task automatic random_phase(input int unsigned atlas, input bit stacking);
    set_atlas(atlas);
    for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
      // Re-pick the idling style now and then, so back-to-back stretches show up too.
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      random_beat(stacking);
    end
    burst = 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, first at the reset page size of 1024.
    beat(FUNC_INSERT, 4096, 4096);   // empty page takes an oversize rectangle at the origin
    beat(FUNC_INSERT, 10, 10);       // nothing fits below it: no space
    beat(FUNC_CLEAR, 0, 0);
    beat(FUNC_INSERT, 0, 0);         // zero-sized first row
    beat(FUNC_INSERT, 0, 0);         // zero-sized rectangle into a zero-height row
    beat(FUNC_INSERT, 100, 20);
    beat(FUNC_INSERT, 50, 20);
    beat(FUNC_INSERT, 30, 10);
    beat(FUNC_INSERT, 1024, 20);
    beat(FUNC_INSERT, 1000, 20);
    beat(FUNC_INSERT, 10, 20);       // two rows of equal height fit: lower index wins
    beat(FUNC_INSERT, 10, 984);      // twenty pixels too tall for a new row
    beat(FUNC_INSERT, 10, 964);      // new row ends exactly on the page edge
    beat(FUNC_INSERT, 8191, 8191);
    beat(FUNC_CLEAR, 8191, 8191);

    set_atlas(1);
    beat(FUNC_INSERT, 1, 1);
    beat(FUNC_INSERT, 1, 1);
    beat(FUNC_INSERT, 0, 0);
    beat(FUNC_CLEAR, 0, 0);

    set_atlas(0);
    beat(FUNC_INSERT, 5, 5);
    beat(FUNC_INSERT, 0, 0);
    beat(FUNC_CLEAR, 0, 0);

    set_atlas(8191);
    beat(FUNC_INSERT, 8191, 1);
    beat(FUNC_INSERT, 0, 8191);
    beat(FUNC_CLEAR, 0, 0);

    // Random part over a spread of page sizes, extremes included.
    random_phase(4096, 1'b1);
    random_phase(1024, 1'b0);
    random_phase(1, 1'b0);
    random_phase(8191, 1'b0);
    random_phase(0, 1'b0);
    random_phase(64, 1'b0);
    random_phase($urandom_range(2, 4096), 1'b0);
    random_phase(4096, 1'b1);
    random_phase(300, 1'b0);

    settle();
    if (mismatches == 0 && awaited == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
